// ----- sv/spq_pkg.sv -----
package spq_pkg;

  localparam int SPQ_DEPTH   = 64;
  localparam int KEY_W       = 32;
  localparam int ID_W        = 8;
  localparam int FILL_W      = 7;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;
  localparam int ENTRY_W     = KEY_W + ID_W;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_POP    = 1'b1
  } req_type_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
  } entry_t;

  typedef struct packed {
    logic [FILL_W-1:0] fill_level;
    logic              was_full;
    logic              was_empty;
    logic [ID_W-1:0]   popped_id;
    logic              done_res;
  } result_t;

endpackage

// ----- sv/sorted_priority_queue.sv -----
// Sequencing: a pop goes IDLE, POP, RESP; a rejected pop or insert goes from IDLE to RESP;
//   an insert runs READ and CMP for each held entry whose key is greater than the new key
//   (one RAM read and one write each) and for the first one that is not, if any, then PUT, RESP.
// Throughput: one transaction at a time; in_tready is high only while the sequencer idles.
// Entries sit in one circular RAM, sorted from head; pop only advances the head pointer.
// Reset (rst_n low, synchronous) empties the queue; RAM contents are left as they are.
module sorted_priority_queue #(
  parameter int DEPTH = spq_pkg::SPQ_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [spq_pkg::IN_TDATA_W-1:0]   in_tdata,  // key[31:0], request_id[39:32]
  input  logic                             in_tuser,  // req_type
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [spq_pkg::OUT_TDATA_W-1:0]  out_tdata  // done_res, popped_id, was_empty,
                                                      // was_full, fill_level, zero pad
);
  import spq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_CMP  = 6'b000100,
    S_PUT  = 6'b001000,
    S_POP  = 6'b010000,
    S_RESP = 6'b100000
  } state_t;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   head_r, head_nxt;
  logic [AW-1:0]   tail_r, tail_nxt;
  logic [AW-1:0]   hole_r, hole_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   left_r, left_nxt;
  entry_t          new_r, new_nxt;
  result_t         res_r, res_nxt;
  logic            out_valid_r, out_valid_nxt;
  result_t         out_data_r, out_data_nxt;

  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  entry_t          wr_data;
  logic [AW-1:0]   rd_addr;
  logic [ENTRY_W-1:0] rd_raw;
  entry_t          rd_entry;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] a);
    ptr_inc = (a == AW'(DEPTH - 1)) ? '0 : a + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] a);
    ptr_dec = (a == '0) ? AW'(DEPTH - 1) : a - AW'(1);
  endfunction

  spq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  assign rd_entry   = entry_t'(rd_raw);
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_data_r);

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    hole_nxt      = hole_r;
    count_nxt     = count_r;
    left_nxt      = left_r;
    new_nxt       = new_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = hole_r;
    wr_data       = new_r;
    rd_addr       = (state_r == S_POP) ? head_r : ptr_dec(hole_r);

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          new_nxt.key = in_tdata[KEY_W-1:0];
          new_nxt.id  = in_tdata[ENTRY_W-1:KEY_W];
          res_nxt     = '0;
          hole_nxt    = tail_r;
          left_nxt    = count_r;
          if (req_type_t'(in_tuser) == REQ_POP) begin
            if (count_r == '0) begin
              res_nxt.was_empty  = 1'b1;
              res_nxt.fill_level = FILL_W'(count_r);
              state_nxt          = S_RESP;
            end else begin
              state_nxt = S_POP;
            end
          end else if (count_r == CW'(DEPTH)) begin
            res_nxt.was_full   = 1'b1;
            res_nxt.fill_level = FILL_W'(count_r);
            state_nxt          = S_RESP;
          end else if (count_r == '0) begin
            state_nxt = S_PUT;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if ($signed(rd_entry.key) > $signed(new_r.key)) begin
          wr_en    = 1'b1;
          wr_data  = rd_entry;
          hole_nxt = ptr_dec(hole_r);
          left_nxt = left_r - CW'(1);
          state_nxt = (left_r == CW'(1)) ? S_PUT : S_READ;
        end else begin
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        wr_en              = 1'b1;
        tail_nxt           = ptr_inc(tail_r);
        count_nxt          = count_r + CW'(1);
        res_nxt.done_res   = 1'b1;
        res_nxt.fill_level = FILL_W'(count_r + CW'(1));
        state_nxt          = S_RESP;
      end
      S_POP: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (state_r == S_RESP && res_r.done_res == 1'b0 && res_r.was_empty == 1'b0
        && res_r.was_full == 1'b0) begin
      res_nxt.done_res   = 1'b1;
      res_nxt.popped_id  = rd_entry.id;
      res_nxt.fill_level = FILL_W'(count_r - CW'(1));
      head_nxt           = ptr_inc(head_r);
      count_nxt          = count_r - CW'(1);
      out_valid_nxt      = out_valid_r && !out_tready;
      state_nxt          = S_RESP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    hole_r     <= hole_nxt;
    left_r     <= left_nxt;
    new_r      <= new_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ----- sv/spq_ram.sv -----
module spq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- tb/sorted_priority_queue_test.sv -----
`timescale 1ns / 100ps

module sorted_priority_queue_test;
  import spq_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 200;
  localparam int ITEMS_PER_PHASE = 185;

  class priority_mirror;
    logic signed [KEY_W-1:0] held_keys [SPQ_DEPTH];
    logic [ID_W-1:0] held_ids [SPQ_DEPTH];
    int held_count;
    result_t pending_results[$];
    int mismatches;

    function new();
      held_count = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // insert behind every entry with key <= new key, pop from the front
    function void note_request(req_type_t kind, logic signed [KEY_W-1:0] k,
                               logic [ID_W-1:0] id);
      result_t r;
      int pos;
      int i;
      r = '0;
      if (kind == REQ_INSERT) begin
        if (held_count >= SPQ_DEPTH) begin
          r.was_full = 1'b1;
        end else begin
          pos = 0;
          while (pos < held_count && held_keys[pos] <= k) pos++;
          for (i = held_count; i > pos; i--) begin
            held_keys[i] = held_keys[i-1];
            held_ids[i] = held_ids[i-1];
          end
          held_keys[pos] = k;
          held_ids[pos] = id;
          held_count++;
          r.done_res = 1'b1;
        end
      end else begin
        if (held_count == 0) begin
          r.was_empty = 1'b1;
        end else begin
          r.popped_id = held_ids[0];
          for (i = 1; i < held_count; i++) begin
            held_keys[i-1] = held_keys[i];
            held_ids[i-1] = held_ids[i];
          end
          held_count--;
          r.done_res = 1'b1;
        end
      end
      r.fill_level = FILL_W'(held_count);
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] data);
      result_t want;
      result_t got;
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: %h", data);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      got = data[$bits(result_t)-1:0];
      compare_field("done_res", want.done_res, got.done_res);
      compare_field("popped_id", want.popped_id, got.popped_id);
      compare_field("was_empty", want.was_empty, got.was_empty);
      compare_field("was_full", want.was_full, got.was_full);
      compare_field("fill_level", want.fill_level, got.fill_level);
      compare_field("pad", 0, int'(data[OUT_TDATA_W-1:$bits(result_t)]));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tuser = REQ_INSERT;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycle_count = 0;
  priority_mirror mirror = new();

  sorted_priority_queue DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) mirror.check_result(out_tdata);
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  task automatic send_request(req_type_t kind, logic [KEY_W-1:0] k, logic [ID_W-1:0] id);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {id, k};
    do @(posedge clk); while (!in_tready);
    mirror.note_request(kind, k, id);
  endtask

  task automatic run_directed();
    send_request(REQ_POP, 32'h1234_5678, 8'hFF);
    send_request(REQ_INSERT, 32'h7FFF_FFFF, 8'hFF);
    send_request(REQ_INSERT, 32'h8000_0000, 8'h00);
    send_request(REQ_INSERT, 32'h0000_0000, 8'hAA);
    send_request(REQ_INSERT, 32'hFFFF_FFFF, 8'h55);
    send_request(REQ_INSERT, 32'd5, 8'd1);
    send_request(REQ_INSERT, 32'd5, 8'd2);
    send_request(REQ_INSERT, 32'd5, 8'd3);
    send_request(REQ_INSERT, 32'h7FFF_FFFF, 8'h7F);
    send_request(REQ_INSERT, 32'h8000_0000, 8'h80);
    repeat (11) send_request(REQ_POP, $urandom, 8'($urandom));
  endtask

  task automatic run_random(int count);
    int insert_pct;
    int key_mode;
    int burst;
    logic [KEY_W-1:0] k;
    while (count > 0) begin
      case ($urandom_range(0, 2))
        0: insert_pct = 95;
        1: insert_pct = 50;
        default: insert_pct = 8;
      endcase
      key_mode = $urandom_range(0, 2);
      burst = $urandom_range(20, 90);
      while (burst > 0 && count > 0) begin
        case ($urandom_range(0, 9) < 2 ? 2 : key_mode)
          0: k = $urandom;
          1: k = 32'(int'($urandom_range(0, 8)) - 4);
          default: begin
            case ($urandom_range(0, 3))
              0: k = 32'h8000_0000;
              1: k = 32'h7FFF_FFFF;
              2: k = 32'h0000_0000;
              default: k = 32'hFFFF_FFFF;
            endcase
          end
        endcase
        if ($urandom_range(0, 99) < insert_pct) send_request(REQ_INSERT, k, 8'($urandom));
        else send_request(REQ_POP, k, 8'($urandom));
        burst--;
        count--;
      end
    end
  endtask

  initial begin
    int phase;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      if (phase == 0) run_directed();
      run_random(ITEMS_PER_PHASE);
    end
    in_tvalid <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mirror.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
sv/spq_pkg.sv
sv/spq_ram.sv
sv/sorted_priority_queue.sv
tb/sorted_priority_queue_test.sv
